// ----- rtl/fca_pkg.sv -----
// Shared types, opcodes and binary32 constants for the float calculator ALU.
// No dependencies; used by fca_fpu and float_calculator_alu.
package fca_pkg;

  // Calculator opcodes as carried on the input channel
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_FACT = 3'd5;

  // Factorial stops multiplying here; the product is already infinite
  localparam logic [5:0] FACT_LIMIT = 6'd40;

  localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
  localparam logic [31:0] FP_INF       = 32'h7F80_0000;
  localparam logic [31:0] FP_QNAN_DEF  = 32'hFFC0_0000;
  localparam logic [31:0] FP_QNAN_POS  = 32'h7FC0_0000;
  localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fpu_op_e;

  typedef struct packed {
    fpu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        vector_mode;
    logic        last_element;
  } calc_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        error_flag;
    logic        last_out;
  } calc_out_t;

  // Exact binary32 encoding of a small nonzero integer
  function automatic logic [31:0] int6_to_fp(input logic [5:0] v);
    logic [2:0] p;
    logic [5:0] nrm;
    p = 3'd0;
    for (int k = 0; k < 6; k++) begin
      if (v[k]) p = 3'(k);
    end
    nrm = v << (3'd5 - p);
    return {1'b0, 8'd127 + {5'b0, p}, nrm[4:0], 18'b0};
  endfunction

endpackage

// ----- rtl/float_calculator_alu.sv -----
// Single-precision calculator ALU: scalar add/sub/mul/div, power, factorial,
// and elementwise vector add/sub/mul. Depends on fca_pkg and fca_fpu.
//
// Usage: one item on the input channel (in_valid_i / in_stall_o, payload
// in_data_i) gives exactly one result on the output channel (out_valid_o /
// out_stall_i, payload out_data_o). A transfer happens on a rising edge with
// valid high and stall low. in_stall_o stays high from the accepted transfer
// until the result has been written into the output register.
// Sequencing: every arithmetic step runs through the one shared fca_fpu unit
// as an issue followed by the unit's busy time, which grows for add/sub when a
// cancellation needs normalizing and for multiply with subnormal operands or
// results. Power takes n multiplies for n = ceil(b) - 1, at most
// MAX_POWER_STEPS; factorial takes floor(a) multiplies, at most 40. Each
// item also passes through accept, prepare, final check and output write.
// Rejected opcodes and saturated power finish with error_flag set and
// result_bits zero.
// Reset clears the sequencer and the output valid; nothing else is kept.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and its result waits for the register to free up.
module float_calculator_alu import fca_pkg::*; #(
  parameter int unsigned MAX_POWER_STEPS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  calc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output calc_out_t out_data_o
);

  localparam int unsigned CntW =
    ($clog2(MAX_POWER_STEPS + 1) > 6) ? $clog2(MAX_POWER_STEPS + 1) : 6;
  localparam logic [23:0] PowLim = 24'(MAX_POWER_STEPS + 1);

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_PREP  = 3'd1;
  localparam logic [2:0] T_ISSUE = 3'd2;
  localparam logic [2:0] T_WAIT  = 3'd3;
  localparam logic [2:0] T_FIN   = 3'd4;

  localparam logic [1:0] M_ONE  = 2'd0;
  localparam logic [1:0] M_POW  = 2'd1;
  localparam logic [1:0] M_FACT = 2'd2;

  logic [2:0]      state_q, state_d;
  logic [1:0]      mode_q, mode_d;
  calc_in_t        in_q;
  logic [31:0]     acc_q, acc_d;
  logic            err_q, err_d;
  logic [CntW-1:0] cnt_q, cnt_d, lim_q, lim_d;
  calc_out_t       out_q;
  logic            out_valid_q;

  logic            in_xfer, out_free;
  logic            fpu_start, fpu_done;
  fpu_req_t        fpu_req;
  logic [31:0]     fpu_res;

  assign in_stall_o = (state_q != T_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // step count decode: floor and fraction of b (power) or a (factorial)
  logic [31:0] src;
  logic [7:0]  se;
  logic [23:0] sm, fl;
  logic [4:0]  sh;
  logic        fracnz, in_rng, src_nan, err_op, b_zero, pow_sat;
  logic [CntW-1:0] pow_n, fact_k;

  always_comb begin
    src     = (in_q.opcode == OP_POW) ? in_q.operand_b : in_q.operand_a;
    se      = src[30:23];
    sm      = {1'b1, src[22:0]};
    sh      = 5'(8'd150 - se);
    fl      = sm >> sh;
    fracnz  = ((fl << sh) != sm);
    in_rng  = (se >= 8'd127) && (se <= 8'd150);
    src_nan = (se == 8'hFF) && (src[22:0] != 23'd0);
    b_zero  = (in_q.operand_b[30:0] == 31'd0);
    pow_sat = !src[31] && !src_nan &&
              ((se > 8'd150) || (in_rng && ((fl > PowLim) || (fl == PowLim && fracnz))));
    pow_n   = (!src[31] && in_rng) ? CntW'(fl + {23'd0, fracnz} - 24'd1) : '0;
    if (src[31] || se < 8'd127 || src_nan) fact_k = '0;
    else if (se >= 8'd133)                 fact_k = CntW'(FACT_LIMIT);
    else if (fl[5:0] > FACT_LIMIT)         fact_k = CntW'(FACT_LIMIT);
    else                                   fact_k = CntW'(fl[5:0]);
    err_op  = (in_q.vector_mode && (in_q.opcode > OP_MUL)) || (in_q.opcode > OP_FACT);
  end

  // request to the shared unit
  always_comb begin
    fpu_req.a = (mode_q == M_ONE) ? in_q.operand_a : acc_q;
    fpu_req.b = in_q.operand_b;
    fpu_req.op = FOP_MUL;
    case (mode_q)
      M_ONE: begin
        case (in_q.opcode)
          OP_ADD:  fpu_req.op = FOP_ADD;
          OP_SUB:  fpu_req.op = FOP_SUB;
          OP_MUL:  fpu_req.op = FOP_MUL;
          default: fpu_req.op = FOP_DIV;
        endcase
      end
      M_POW:   fpu_req.b = in_q.operand_a;
      default: fpu_req.b = int6_to_fp(cnt_q[5:0] + 6'd1);
    endcase
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    acc_d     = acc_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    lim_d     = lim_q;
    fpu_start = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (in_xfer) state_d = T_PREP;
      end
      T_PREP: begin
        err_d   = 1'b0;
        cnt_d   = '0;
        state_d = T_ISSUE;
        if (err_op) begin
          err_d   = 1'b1;
          acc_d   = 32'd0;
          state_d = T_FIN;
        end else begin
          case (in_q.opcode)
            OP_POW: begin
              mode_d = M_POW;
              if (b_zero) begin
                acc_d = FP_ONE;
                lim_d = '0;
              end else if (pow_sat) begin
                err_d   = 1'b1;
                acc_d   = 32'd0;
                state_d = T_FIN;
              end else begin
                acc_d = in_q.operand_a;
                lim_d = pow_n;
              end
            end
            OP_FACT: begin
              mode_d = M_FACT;
              acc_d  = FP_ONE;
              lim_d  = fact_k;
            end
            default: begin
              mode_d = M_ONE;
              lim_d  = CntW'(1);
            end
          endcase
        end
      end
      T_ISSUE: begin
        if (cnt_q == lim_q) begin
          state_d = T_FIN;
        end else begin
          fpu_start = 1'b1;
          state_d   = T_WAIT;
        end
      end
      T_WAIT: begin
        if (fpu_done) begin
          acc_d   = fpu_res;
          cnt_d   = cnt_q + CntW'(1);
          state_d = T_ISSUE;
        end
      end
      T_FIN: begin
        if (out_free) state_d = T_IDLE;
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  fca_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fpu_start),
    .req_i   (fpu_req),
    .done_o  (fpu_done),
    .res_o   (fpu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == T_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    acc_q  <= acc_d;
    err_q  <= err_d;
    cnt_q  <= cnt_d;
    lim_q  <= lim_d;
    if (in_xfer) in_q <= in_data_i;
    if (state_q == T_FIN && out_free) begin
      out_q.result_bits <= acc_q;
      out_q.error_flag  <= err_q;
      out_q.last_out    <= in_q.last_element;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_done |-> state_q == T_WAIT)
    else $error("fpu result arrived outside of wait");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_ISSUE || state_q == T_WAIT) |-> cnt_q <= lim_q)
    else $error("step counter passed its limit");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_flag |-> out_data_o.result_bits == 32'd0)
    else $error("error result carries nonzero bits");
  a_wait_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_WAIT && !fpu_done |=> state_q == T_WAIT)
    else $error("left wait without fpu result");

endmodule

// ----- rtl/fca_fpu.sv -----
// Multi-cycle binary32 add/sub/mul/div unit with round to nearest-even.
// Depends on fca_pkg for the request type, opcodes and constants.
module fca_fpu import fca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  fpu_req_t    req_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRE   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_MULP  = 4'd3;
  localparam logic [3:0] S_DIVI  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_ALIGN = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_NORM  = 4'd8;
  localparam logic [3:0] S_ROUND = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]         state_q, state_d;
  fpu_op_e            op_q, op_d;
  logic signed [10:0] ea_q, ea_d, eb_q, eb_d, exp_q, exp_d;
  logic [23:0]        ma_q, ma_d, mb_q, mb_d;
  logic               sign_q, sign_d, sub_q, sub_d;
  logic [27:0]        m_q, m_d, ysh_q, ysh_d;
  logic [47:0]        prod_q, prod_d;
  logic [25:0]        quo_q, quo_d;
  logic [24:0]        rem_q, rem_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [31:0]        res_q, res_d;

  // operand decode
  logic [7:0]         ae, be;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic               sbe, sx, a_ge, special;
  logic [31:0]        spec_res;
  logic signed [10:0] ea_un, eb_un;
  logic [23:0]        ma_un, mb_un;

  assign ae     = req_i.a[30:23];
  assign be     = req_i.b[30:23];
  assign a_nan  = (ae == 8'hFF) && (req_i.a[22:0] != 23'd0);
  assign b_nan  = (be == 8'hFF) && (req_i.b[22:0] != 23'd0);
  assign a_inf  = (ae == 8'hFF) && (req_i.a[22:0] == 23'd0);
  assign b_inf  = (be == 8'hFF) && (req_i.b[22:0] == 23'd0);
  assign a_zero = (req_i.a[30:0] == 31'd0);
  assign b_zero = (req_i.b[30:0] == 31'd0);
  assign sbe    = req_i.b[31] ^ (req_i.op == FOP_SUB);
  assign sx     = req_i.a[31] ^ req_i.b[31];
  assign a_ge   = (req_i.a[30:0] >= req_i.b[30:0]);
  assign ea_un  = (ae == 8'd0) ? 11'sd1 : $signed({3'b0, ae});
  assign eb_un  = (be == 8'd0) ? 11'sd1 : $signed({3'b0, be});
  assign ma_un  = {ae != 8'd0, req_i.a[22:0]};
  assign mb_un  = {be != 8'd0, req_i.b[22:0]};

  always_comb begin
    special  = 1'b1;
    spec_res = 32'd0;
    if (req_i.op == FOP_DIV && b_zero) begin
      if (a_nan)       spec_res = req_i.a | FP_QUIET_BIT;
      else if (a_zero) spec_res = FP_QNAN_POS;
      else             spec_res = {sx, FP_INF[30:0]};
    end else if (a_nan) begin
      spec_res = req_i.a | FP_QUIET_BIT;
    end else if (b_nan) begin
      spec_res = req_i.b | FP_QUIET_BIT;
    end else begin
      case (req_i.op)
        FOP_ADD, FOP_SUB: begin
          if (a_inf && b_inf && (req_i.a[31] != sbe)) spec_res = FP_QNAN_DEF;
          else if (a_inf)                             spec_res = req_i.a;
          else if (b_inf)                             spec_res = {sbe, FP_INF[30:0]};
          else                                        special  = 1'b0;
        end
        FOP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = FP_QNAN_DEF;
          else if (a_inf || b_inf)                    spec_res = {sx, FP_INF[30:0]};
          else if (a_zero || b_zero)                  spec_res = {sx, 31'd0};
          else                                        special  = 1'b0;
        end
        default: begin
          if (a_inf && b_inf)       spec_res = FP_QNAN_DEF;
          else if (a_inf)           spec_res = {sx, FP_INF[30:0]};
          else if (b_inf || a_zero) spec_res = {sx, 31'd0};
          else                      special  = 1'b0;
        end
      endcase
    end
  end

  // datapath helpers
  logic signed [10:0] dexp;
  logic [27:0]        yfull, yshift;
  logic [4:0]         sh5;
  logic [27:0]        xfull;
  logic [25:0]        diff;
  logic               ge;
  logic [24:0]        rn;
  logic               rinc;
  logic [24:0]        mant25;
  logic [23:0]        mant;
  logic signed [10:0] efin;

  always_comb begin
    dexp   = ea_q - eb_q;
    yfull  = {1'b0, mb_q, 3'b0};
    sh5    = dexp[4:0];
    if (dexp > 11'sd27) begin
      yshift = {27'd0, |yfull};
    end else begin
      yshift    = yfull >> sh5;
      yshift[0] = yshift[0] | (|(yfull & ~(28'hFFF_FFFF << sh5)));
    end
    xfull  = {1'b0, ma_q, 3'b0};
    diff   = {1'b0, rem_q} - {2'b0, mb_q};
    ge     = !diff[25];
    rn     = ge ? diff[24:0] : rem_q;
    rinc   = m_q[2] & (m_q[3] | m_q[1] | m_q[0]);
    mant25 = {1'b0, m_q[26:3]} + {24'd0, rinc};
    mant   = mant25[24] ? mant25[24:1] : mant25[23:0];
    efin   = mant25[24] ? exp_q + 11'sd1 : exp_q;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    sign_d  = sign_q;
    sub_d   = sub_q;
    exp_d   = exp_q;
    m_d     = m_q;
    ysh_d   = ysh_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = req_i.op;
          if (special) begin
            res_d   = spec_res;
            state_d = S_DONE;
          end else if (req_i.op == FOP_ADD || req_i.op == FOP_SUB) begin
            // larger magnitude goes first so the difference stays positive
            sub_d = req_i.a[31] ^ sbe;
            if (a_ge) begin
              ea_d = ea_un; ma_d = ma_un; eb_d = eb_un; mb_d = mb_un;
              sign_d = req_i.a[31];
            end else begin
              ea_d = eb_un; ma_d = mb_un; eb_d = ea_un; mb_d = ma_un;
              sign_d = sbe;
            end
            state_d = S_ALIGN;
          end else begin
            ea_d = ea_un; ma_d = ma_un; eb_d = eb_un; mb_d = mb_un;
            sign_d  = sx;
            sub_d   = 1'b0;
            state_d = S_PRE;
          end
        end
      end
      S_PRE: begin
        // bring subnormal mantissas up to a leading one
        if (!ma_q[23]) begin
          ma_d = {ma_q[22:0], 1'b0};
          ea_d = ea_q - 11'sd1;
        end else if (!mb_q[23]) begin
          mb_d = {mb_q[22:0], 1'b0};
          eb_d = eb_q - 11'sd1;
        end else begin
          state_d = (op_q == FOP_MUL) ? S_MUL : S_DIVI;
        end
      end
      S_MUL: begin
        prod_d  = ma_q * mb_q;
        exp_d   = ea_q + eb_q - 11'sd127;
        state_d = S_MULP;
      end
      S_MULP: begin
        m_d     = {prod_q[47:21], |prod_q[20:0]};
        state_d = S_NORM;
      end
      S_DIVI: begin
        if (ma_q < mb_q) begin
          rem_d = {ma_q, 1'b0};
          exp_d = ea_q - eb_q + 11'sd126;
        end else begin
          rem_d = {1'b0, ma_q};
          exp_d = ea_q - eb_q + 11'sd127;
        end
        quo_d   = 26'd0;
        cnt_d   = 5'd0;
        state_d = S_DIV;
      end
      S_DIV: begin
        quo_d = {quo_q[24:0], ge};
        rem_d = {rn[23:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd25) begin
          m_d     = {1'b0, quo_q[24:0], ge, rn != 25'd0};
          state_d = S_NORM;
        end
      end
      S_ALIGN: begin
        ysh_d   = yshift;
        state_d = S_ADD;
      end
      S_ADD: begin
        m_d     = sub_q ? xfull - ysh_q : xfull + ysh_q;
        exp_d   = ea_q;
        state_d = S_NORM;
      end
      S_NORM: begin
        if (m_q == 28'd0) begin
          // exact cancellation gives +0 under nearest-even
          res_d   = {sub_q ? 1'b0 : sign_q, 31'd0};
          state_d = S_DONE;
        end else if (m_q[27]) begin
          m_d   = {1'b0, m_q[27:2], m_q[1] | m_q[0]};
          exp_d = exp_q + 11'sd1;
        end else if (exp_q < -11'sd26) begin
          m_d   = 28'd1;
          exp_d = 11'sd1;
        end else if (exp_q < 11'sd1) begin
          m_d   = {1'b0, m_q[27:2], m_q[1] | m_q[0]};
          exp_d = exp_q + 11'sd1;
        end else if (!m_q[26] && exp_q > 11'sd1) begin
          m_d   = {m_q[26:0], 1'b0};
          exp_d = exp_q - 11'sd1;
        end else begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (efin >= 11'sd255) res_d = {sign_q, FP_INF[30:0]};
        else res_d = {sign_q, mant[23] ? efin[7:0] : 8'd0, mant[22:0]};
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    sign_q <= sign_d;
    sub_q  <= sub_d;
    exp_q  <= exp_d;
    m_q    <= m_d;
    ysh_q  <= ysh_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign done_o = (state_q == S_DONE);
  assign res_o  = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && state_q != S_IDLE |-> 1'b0)
    else $error("fpu started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("fpu done held for more than one cycle");
  a_round_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> !m_q[27] && exp_q >= 11'sd1)
    else $error("rounding entered with unnormalized mantissa");

endmodule

// ----- tb/float_calculator_alu_test.sv -----
// Self-checking testbench for float_calculator_alu: random and directed items,
// bit-exact binary32 prediction with round-to-nearest-even, random idling.
// Depends on fca_pkg and the float_calculator_alu RTL.
module float_calculator_alu_test import fca_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POW_CAP = 256;
  localparam int unsigned N_RANDOM = 1500;
  localparam int unsigned QUIET_TAIL = 150;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  calc_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  calc_out_t out_data_o;

  calc_in_t  stim_q[$];
  calc_out_t result_q[$];
  int        err_count = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        in_took = 1'b0;

  float_calculator_alu #(.MAX_POWER_STEPS(POW_CAP)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  // ---------------- binary32 arithmetic ----------------
  function automatic bit fp_is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit fp_is_inf(input logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  function automatic bit fp_is_zero(input logic [31:0] x);
    return x[30:0] == 0;
  endfunction

  function automatic void fp_unpack(input logic [31:0] x, output logic [63:0] sig,
                                    output int e);
    if (x[30:23] == 0) begin
      sig = {41'b0, x[22:0]};
      e = -149;
    end else begin
      sig = {40'b0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // Round sig * 2^e (sig nonzero) to binary32, nearest-even
  function automatic logic [31:0] fp_round(input logic s, input int e, input logic [63:0] sig);
    int p, sh, ee;
    logic [127:0] w, kp;
    logic rb, st;
    p = 0;
    for (int k = 0; k < 64; k++) if (sig[k]) p = k;
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    w = {64'b0, sig};
    if (sh <= 0) begin
      kp = w << (-sh);
      rb = 1'b0;
      st = 1'b0;
    end else begin
      if (sh > 100) sh = 100;
      kp = w >> sh;
      rb = w[sh-1];
      st = (w & ((128'd1 << (sh - 1)) - 1)) != 0;
    end
    if (rb && (st || kp[0])) kp = kp + 1;
    ee = sh + e + 150;
    if (kp[24]) begin
      kp = kp >> 1;
      ee++;
    end
    if (kp == 0) return {s, 31'b0};
    if (!kp[23]) return {s, 8'd0, kp[22:0]};
    if (ee >= 255) return {s, 8'hFF, 23'b0};
    return {s, ee[7:0], kp[22:0]};
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] sa, sb, big, sm, sum, tsig;
    int ea, eb, te, d;
    logic sga, sgb, tsg, rs;
    if (fp_is_nan(a)) return a | FP_QUIET_BIT;
    if (fp_is_nan(b)) return b | FP_QUIET_BIT;
    if (fp_is_inf(a) && fp_is_inf(b) && a[31] != b[31]) return FP_QNAN_DEF;
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    if (fp_is_zero(a) && fp_is_zero(b)) return {a[31] & b[31], 31'b0};
    if (fp_is_zero(a)) return b;
    if (fp_is_zero(b)) return a;
    fp_unpack(a, sa, ea);
    fp_unpack(b, sb, eb);
    sga = a[31];
    sgb = b[31];
    if (ea < eb) begin
      tsig = sa; sa = sb; sb = tsig;
      te = ea; ea = eb; eb = te;
      tsg = sga; sga = sgb; sgb = tsg;
    end
    big = sa << 30;
    d = ea - eb;
    if (d <= 30) sm = sb << (30 - d);
    else if (d >= 64) sm = 64'(sb != 0);
    else sm = (sb >> (d - 30)) | 64'((sb & ((64'd1 << (d - 30)) - 1)) != 0);
    if (sga == sgb) begin
      sum = big + sm;
      rs = sga;
    end else if (big >= sm) begin
      sum = big - sm;
      rs = sga;
    end else begin
      sum = sm - big;
      rs = sgb;
    end
    if (sum == 0) return 32'h0;
    return fp_round(rs, ea - 30, sum);
  endfunction

  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    return fp_add(a, fp_is_nan(b) ? b : {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] sa, sb;
    int ea, eb;
    logic s;
    if (fp_is_nan(a)) return a | FP_QUIET_BIT;
    if (fp_is_nan(b)) return b | FP_QUIET_BIT;
    if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b)))
      return FP_QNAN_DEF;
    s = a[31] ^ b[31];
    if (fp_is_inf(a) || fp_is_inf(b)) return {s, 8'hFF, 23'b0};
    if (fp_is_zero(a) || fp_is_zero(b)) return {s, 31'b0};
    fp_unpack(a, sa, ea);
    fp_unpack(b, sb, eb);
    return fp_round(s, ea + eb, sa * sb);
  endfunction

  function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] sa, sb, q, r;
    int ea, eb;
    logic s;
    s = a[31] ^ b[31];
    if (fp_is_zero(b)) begin
      if (fp_is_nan(a)) return a | FP_QUIET_BIT;
      if (fp_is_zero(a)) return FP_QNAN_POS;
      return {s, 8'hFF, 23'b0};
    end
    if (fp_is_nan(a)) return a | FP_QUIET_BIT;
    if (fp_is_nan(b)) return b | FP_QUIET_BIT;
    if (fp_is_inf(a) && fp_is_inf(b)) return FP_QNAN_DEF;
    if (fp_is_inf(a)) return {s, 8'hFF, 23'b0};
    if (fp_is_inf(b) || fp_is_zero(a)) return {s, 31'b0};
    fp_unpack(a, sa, ea);
    fp_unpack(b, sb, eb);
    while (!sa[23]) begin
      sa = sa << 1;
      ea--;
    end
    while (!sb[23]) begin
      sb = sb << 1;
      eb--;
    end
    q = (sa << 40) / sb;
    r = (sa << 40) % sb;
    return fp_round(s, ea - eb - 41, (q << 1) | 64'(r != 0));
  endfunction

  // x < y for operands that are not NaN
  function automatic bit fp_less(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] kx, ky;
    if (fp_is_zero(x) && fp_is_zero(y)) return 1'b0;
    kx = x[31] ? ~x : (x | 32'h8000_0000);
    ky = y[31] ? ~y : (y | 32'h8000_0000);
    return kx < ky;
  endfunction

  function automatic logic [31:0] int_to_fp(input int unsigned v);
    int p;
    logic [31:0] m;
    if (v == 0) return 32'h0;
    p = 0;
    for (int k = 0; k < 24; k++) if (v[k]) p = k;
    m = v << (23 - p);
    return {1'b0, 8'(127 + p), m[22:0]};
  endfunction

  function automatic calc_out_t calc_model(input calc_in_t it);
    calc_out_t o;
    logic [31:0] r;
    o.last_out = it.last_element;
    o.error_flag = 1'b0;
    r = '0;
    if (it.vector_mode && it.opcode > OP_MUL) begin
      o.error_flag = 1'b1;
    end else begin
      case (it.opcode)
        OP_ADD: r = fp_add(it.operand_a, it.operand_b);
        OP_SUB: r = fp_sub(it.operand_a, it.operand_b);
        OP_MUL: r = fp_mul(it.operand_a, it.operand_b);
        OP_DIV: r = fp_div(it.operand_a, it.operand_b);
        OP_POW: begin
          if (fp_is_zero(it.operand_b)) begin
            r = FP_ONE;
          end else if (!fp_is_nan(it.operand_b) &&
                       fp_less(int_to_fp(POW_CAP + 1), it.operand_b)) begin
            o.error_flag = 1'b1;
          end else begin
            r = it.operand_a;
            for (int unsigned i = 1; i <= POW_CAP; i++) begin
              if (fp_is_nan(it.operand_b) || !fp_less(int_to_fp(i), it.operand_b)) break;
              r = fp_mul(r, it.operand_a);
            end
          end
        end
        OP_FACT: begin
          r = FP_ONE;
          for (int unsigned i = 1; i <= FACT_LIMIT; i++) begin
            if (fp_is_nan(it.operand_a) || fp_less(it.operand_a, int_to_fp(i))) break;
            r = fp_mul(r, int_to_fp(i));
          end
        end
        default: o.error_flag = 1'b1;
      endcase
    end
    o.result_bits = o.error_flag ? 32'h0 : r;
    return o;
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [31:0] rand_fp();
    logic s;
    s = 1'($urandom);
    case ($urandom % 8)
      0, 7: return $urandom;
      1, 2: return {s, 8'($urandom_range(120, 134)), 23'($urandom)};
      3: begin
        case ($urandom % 8)
          0: return {s, 31'h0};
          1: return {s, 31'h7F80_0000};
          2: return {s, 8'hFF, 1'b1, 22'($urandom)};
          3: return {s, 8'hFF, 1'b0, 22'($urandom) | 22'd1};
          4: return {s, 31'h7F7F_FFFF};
          5: return {s, 31'h0080_0000};
          6: return {s, 31'h0000_0001};
          default: return {s, 31'h3F80_0000};
        endcase
      end
      4: return {s, 8'd0, 23'($urandom)};
      default: return {s, 8'($urandom_range(1, 254)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_exponent();
    case ($urandom % 10)
      0, 1, 2, 3: return int_to_fp($urandom_range(0, 12));
      4: return {1'b0, 8'($urandom_range(118, 130)), 23'($urandom)};
      5, 6: return rand_fp();
      7: return int_to_fp($urandom_range(0, 20)) | 32'h8000_0000;
      8: return int_to_fp($urandom_range(13, 40));
      default: begin
        if ($urandom % 20 == 0) begin
          case ($urandom % 4)
            0: return int_to_fp(POW_CAP);
            1: return int_to_fp(POW_CAP + 1);
            2: return int_to_fp(POW_CAP + 2);
            default: return FP_INF;
          endcase
        end
        return int_to_fp($urandom_range(0, 8));
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_fact_arg();
    case ($urandom % 4)
      0, 1: return int_to_fp($urandom_range(0, 42));
      2: return {1'($urandom), 8'($urandom_range(120, 133)), 23'($urandom)};
      default: return rand_fp();
    endcase
  endfunction

  function automatic calc_in_t mk_item(input logic [2:0] op, input logic [31:0] a,
                                       input logic [31:0] b, input logic vec,
                                       input logic last);
    calc_in_t it;
    it.opcode = op;
    it.operand_a = a;
    it.operand_b = b;
    it.vector_mode = vec;
    it.last_element = last;
    return it;
  endfunction

  task automatic load_directed();
    stim_q.push_back(mk_item(OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_SUB, FP_INF, FP_INF, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_SUB, 32'h3F80_0000, 32'h3F80_0000, 1'b0, 1'b0));
    stim_q.push_back(mk_item(OP_MUL, 32'h0000_0000, FP_INF, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_MUL, 32'h0080_0001, 32'h3F00_0001, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_ADD, 32'hFF80_0001, 32'h3F80_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_DIV, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_DIV, FP_ONE, 32'h8000_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_DIV, 32'hBF80_0000, 32'h0000_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_DIV, 32'h7F80_0001, 32'h0000_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_DIV, 32'h4049_0FDB, 32'h0000_0003, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'h4000_0000, 32'h0000_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'h4000_0000, 32'h8000_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'h4000_0000, 32'h3F00_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'hC000_0000, 32'h4040_0000, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'h3F80_0001, int_to_fp(POW_CAP + 1), 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'h3F80_0000, int_to_fp(POW_CAP + 2), 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'h3F80_0000, FP_INF, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_POW, 32'h4000_0000, FP_QNAN_POS, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_FACT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_FACT, 32'h40A0_0000, 32'h0, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_FACT, int_to_fp(35), 32'h0, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_FACT, 32'h4222_0000, 32'h0, 1'b0, 1'b1));
    stim_q.push_back(mk_item(OP_FACT, 32'hFFC0_0000, 32'h0, 1'b0, 1'b1));
    stim_q.push_back(mk_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    stim_q.push_back(mk_item(3'd7, 32'h0, 32'h0, 1'b1, 1'b0));
    stim_q.push_back(mk_item(OP_DIV, FP_ONE, FP_ONE, 1'b1, 1'b0));
    stim_q.push_back(mk_item(OP_ADD, 32'h4000_0000, 32'h4040_0000, 1'b1, 1'b0));
    stim_q.push_back(mk_item(OP_POW, FP_ONE, FP_ONE, 1'b1, 1'b1));
  endtask

  task automatic load_random();
    logic [2:0] op;
    logic vec;
    for (int n = 0; n < N_RANDOM; n++) begin
      op = ($urandom % 16 == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      vec = ($urandom % 4 == 0);
      case (op)
        OP_POW:  stim_q.push_back(mk_item(op, rand_fp(), rand_exponent(), vec, 1'($urandom)));
        OP_FACT: stim_q.push_back(mk_item(op, rand_fact_arg(), $urandom, vec, 1'($urandom)));
        default: stim_q.push_back(mk_item(op, rand_fp(), rand_fp(), vec, 1'($urandom)));
      endcase
    end
  endtask

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        in_took = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (stim_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          in_data_i <= stim_q.pop_front();
          in_valid_i <= 1'b1;
          if (stim_q.size() > QUIET_TAIL && $urandom % 6 == 0)
            in_gap = $urandom_range(1, 12);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (stim_q.size() > QUIET_TAIL && $urandom % 6 == 0)
          out_gap = $urandom_range(1, 12);
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch on %s: got %h expected %h", $realtime, field, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    calc_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        result_q.push_back(calc_model(in_data_i));
        in_took = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          flag_mismatch("unexpected transfer", out_data_o.result_bits, 32'h0);
        end else begin
          want = result_q.pop_front();
          if (out_data_o.result_bits !== want.result_bits)
            flag_mismatch("result_bits", out_data_o.result_bits, want.result_bits);
          if (out_data_o.error_flag !== want.error_flag)
            flag_mismatch("error_flag", 32'(out_data_o.error_flag), 32'(want.error_flag));
          if (out_data_o.last_out !== want.last_out)
            flag_mismatch("last_out", 32'(out_data_o.last_out), 32'(want.last_out));
        end
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    load_directed();
    load_random();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (stim_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && result_q.size() == 0) begin
      $display("float_calculator_alu_test: PASS");
    end else begin
      $display("float_calculator_alu_test: FAIL");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("float_calculator_alu_test: FAIL");
    $finish;
  end

endmodule
